>>> hw/rtl/ps2mpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types and constants for the ps/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  localparam int unsigned PosW    = 31;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OutW    = 2 * PosW + 2 + ByteW;
  localparam int unsigned OutTdW  = ((OutW + 7) / 8) * 8;

  localparam logic [PosW-1:0] PosMax    = {PosW{1'b1}};
  localparam logic [PosW-1:0] PosXReset = PosW'(40);
  localparam logic [PosW-1:0] PosYReset = PosW'(12);

  // position of a byte inside a three-byte packet
  typedef enum logic [1:0] {
    IDX_BUTTONS = 2'd0,
    IDX_DX      = 2'd1,
    IDX_DY      = 2'd2,
    IDX_SPARE   = 2'd3
  } byte_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] button_byte;
    logic             button_flag;
    logic             moved;
    logic [PosW-1:0]  y_position;
    logic [PosW-1:0]  x_position;
  } result_t;

endpackage

>>> hw/rtl/ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Gathers mouse bytes into three-byte packets and tracks absolute position.
// ----------------------------------------------------------------------------
// Input stream: one controller byte per transaction in s_axis_tdata, with the
// auxiliary-data flag in s_axis_tuser. Bytes without the flag are dropped.
// Every third flagged byte completes a packet and yields one transaction on
// the output stream carrying the clamped x/y position, the moved flag, the
// press flag and the packet's button byte.
// Throughput is one byte per cycle. A byte sits in the input register, is
// processed by the packet logic and the completed result lands in the output
// register, so a packet result passes through the input register and then the
// output register once its third byte is accepted.
// When the receiver stalls, the output register holds its result; bytes that
// do not complete a packet keep flowing, and a completing byte waits in the
// input register until the output register frees up, with s_axis_tready low
// while it waits.
// Reset clears the packet index and button history and loads the position
// to x = 40, y = 12.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] data_byte
  input  logic [7:0]                     s_axis_tdata,
  // [0] aux_ready
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [30:0] x_position, [61:31] y_position, [62] moved, [63] button_flag,
  // [71:64] button_byte
  output logic [ps2mpt_pkg::OutTdW-1:0]  m_axis_tdata
);
  import ps2mpt_pkg::*;

  // input register
  logic             in_vld_q, in_vld_d;
  logic             in_aux_q;
  logic [ByteW-1:0] in_byte_q;

  // packet state
  byte_idx_e        idx_q, idx_d;
  logic [ByteW-1:0] b0_q, b0_d;
  logic [ByteW-1:0] b1_q, b1_d;
  logic [ByteW-1:0] last_btn_q, last_btn_d;
  logic             press_q, press_d;
  logic [PosW-1:0]  pos_x_q, pos_x_d;
  logic [PosW-1:0]  pos_y_q, pos_y_d;

  // output register
  logic             out_vld_q, out_vld_d;
  result_t          res_q, res_d;

  logic             completes;
  logic             advance;
  logic             out_free;
  logic [PosW+1:0]  sum_x;
  logic [PosW+1:0]  sum_y;
  logic [8:0]       dy_neg;
  logic [2:0]       changed;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign completes = in_aux_q && (idx_q == IDX_DY || idx_q == IDX_SPARE);
  assign advance   = in_vld_q && (!completes || out_free);

  assign s_axis_tready = !in_vld_q || advance;
  assign in_vld_d      = s_axis_tvalid ? 1'b1 : (in_vld_q && !advance);

  // y delta is negated; -(-128) = +128 still fits in 9 signed bits
  assign dy_neg  = 9'd0 - {in_byte_q[7], in_byte_q};
  assign sum_x   = {2'b00, pos_x_q} + {{(PosW-6){b1_q[7]}}, b1_q};
  assign sum_y   = {2'b00, pos_y_q} + {{(PosW-7){dy_neg[8]}}, dy_neg};
  assign changed = b0_q[2:0] ^ last_btn_q[2:0];

  always_comb begin
    idx_d      = idx_q;
    b0_d       = b0_q;
    b1_d       = b1_q;
    last_btn_d = last_btn_q;
    press_d    = press_q;
    pos_x_d    = pos_x_q;
    pos_y_d    = pos_y_q;
    if (advance && in_aux_q) begin
      unique case (idx_q) inside
        IDX_BUTTONS: begin
          b0_d  = in_byte_q;
          idx_d = IDX_DX;
        end
        IDX_DX: begin
          b1_d  = in_byte_q;
          idx_d = IDX_DY;
        end
        IDX_DY, IDX_SPARE: begin
          idx_d = IDX_BUTTONS;
          // negative sum clamps to zero, overflow past bit 30 saturates
          if (sum_x[PosW+1])    pos_x_d = '0;
          else if (sum_x[PosW]) pos_x_d = PosMax;
          else                  pos_x_d = sum_x[PosW-1:0];
          if (sum_y[PosW+1])    pos_y_d = '0;
          else if (sum_y[PosW]) pos_y_d = PosMax;
          else                  pos_y_d = sum_y[PosW-1:0];
          // highest changed button decides the flag
          if (changed[2])      press_d = !last_btn_q[2];
          else if (changed[1]) press_d = !last_btn_q[1];
          else if (changed[0]) press_d = !last_btn_q[0];
          last_btn_d = b0_q;
        end
        default: idx_d = IDX_BUTTONS;
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    res_d     = res_q;
    if (advance && completes) begin
      out_vld_d         = 1'b1;
      res_d.x_position  = pos_x_d;
      res_d.y_position  = pos_y_d;
      res_d.moved       = (b1_q != '0) || (in_byte_q != '0);
      res_d.button_flag = press_d;
      res_d.button_byte = b0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      idx_q      <= IDX_BUTTONS;
      b0_q       <= '0;
      b1_q       <= '0;
      last_btn_q <= '0;
      press_q    <= 1'b0;
      pos_x_q    <= PosXReset;
      pos_y_q    <= PosYReset;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= in_vld_d;
      idx_q      <= idx_d;
      b0_q       <= b0_d;
      b1_q       <= b1_d;
      last_btn_q <= last_btn_d;
      press_q    <= press_d;
      pos_x_q    <= pos_x_d;
      pos_y_q    <= pos_y_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_aux_q  <= s_axis_tuser[0];
      in_byte_q <= s_axis_tdata;
    end
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutTdW'(res_q);

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the ps/2 mouse packet tracker. A queue of controller
// bytes feeds a clocked driver; a clocked monitor compares each packet result
// against a behavioral tracker of position, press flag and button history.
// Directed packets cover the clamp, sign and button corners, then random
// packets mixed with unflagged bytes run under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import ps2mpt_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned FlaggedTarget = 1850;
  localparam int unsigned SteadyLo      = 400;
  localparam int unsigned SteadyHi      = 700;
  localparam int unsigned HoldAt        = 1000;
  localparam int unsigned HoldCycles    = 180;

  typedef struct {
    logic       aux;
    logic [7:0] data;
    bit         drain;   // wait for every packet result before offering
  } ctrl_byte_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutTdW-1:0]     m_axis_tdata;

  ps2_mouse_packet_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ctrl_byte_t  byte_queue[$];
  result_t     packet_results[$];
  int unsigned bytes_taken   = 0;
  int unsigned errors        = 0;
  int unsigned flagged_count = 0;
  int unsigned hold_left     = 0;
  bit          hold_done     = 1'b0;
  int unsigned quiet_cycles  = 0;

  // tracker state
  logic [7:0]      pkt_buf[3];
  byte_idx_e       pkt_idx;
  logic [7:0]      last_btn;
  logic            press;
  logic [PosW-1:0] pos_x;
  logic [PosW-1:0] pos_y;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [PosW-1:0] clamp_add(logic [PosW-1:0] pos, int delta);
    longint v;
    v = longint'(pos) + delta;
    if (v < 0) v = 0;
    if (v > longint'(PosMax)) v = longint'(PosMax);
    return v[PosW-1:0];
  endfunction

  task automatic track_byte(ctrl_byte_t cb);
    result_t r;
    int      dx;
    int      dy;
    if (!cb.aux) return;
    pkt_buf[int'(pkt_idx)] = cb.data;
    if (pkt_idx == IDX_BUTTONS || pkt_idx == IDX_DX) begin
      pkt_idx = byte_idx_e'(pkt_idx + 2'd1);
      return;
    end
    pkt_idx = IDX_BUTTONS;
    dx = $signed(pkt_buf[1]);
    dy = $signed(pkt_buf[2]);
    dy = -dy;
    pos_x = clamp_add(pos_x, dx);
    pos_y = clamp_add(pos_y, dy);
    // walk bits upward so the highest changed button decides
    for (int i = 0; i < 3; i++) begin
      if (pkt_buf[0][i] != last_btn[i]) press = ~last_btn[i];
    end
    last_btn = pkt_buf[0];
    r.x_position  = pos_x;
    r.y_position  = pos_y;
    r.moved       = (pkt_buf[1] != 8'h00) || (pkt_buf[2] != 8'h00);
    r.button_flag = press;
    r.button_byte = pkt_buf[0];
    packet_results.push_back(r);
  endtask

  task automatic check_result(result_t got);
    result_t exp;
    if (packet_results.size() == 0) begin
      $error("unexpected result transaction: %h", got);
      errors++;
      return;
    end
    exp = packet_results.pop_front();
    if (got.x_position !== exp.x_position) begin
      $error("x_position: expected %0d, got %0d", exp.x_position, got.x_position);
      errors++;
    end
    if (got.y_position !== exp.y_position) begin
      $error("y_position: expected %0d, got %0d", exp.y_position, got.y_position);
      errors++;
    end
    if (got.moved !== exp.moved) begin
      $error("moved: expected %0b, got %0b", exp.moved, got.moved);
      errors++;
    end
    if (got.button_flag !== exp.button_flag) begin
      $error("button_flag: expected %0b, got %0b", exp.button_flag, got.button_flag);
      errors++;
    end
    if (got.button_byte !== exp.button_byte) begin
      $error("button_byte: expected %h, got %h", exp.button_byte, got.button_byte);
      errors++;
    end
  endtask

  task automatic push_byte(logic aux, logic [7:0] data, bit drain = 1'b0);
    ctrl_byte_t cb;
    cb.aux   = aux;
    cb.data  = data;
    cb.drain = drain;
    byte_queue.push_back(cb);
    if (aux) flagged_count++;
  endtask

  task automatic push_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             bit drain = 1'b0);
    push_byte(1'b1, b0, drain);
    push_byte(1'b1, b1);
    push_byte(1'b1, b2);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic       nxt_valid;
    bit         taken;
    bit         steady;
    if (rst_ni) begin
      taken = s_axis_tvalid && s_axis_tready;
      if (taken) begin
        track_byte(byte_queue.pop_front());
        bytes_taken++;
      end
      steady    = bytes_taken >= SteadyLo && bytes_taken < SteadyHi;
      nxt_valid = 1'b0;
      if (byte_queue.size() != 0) begin
        if (s_axis_tvalid && !taken) nxt_valid = 1'b1;
        else if (byte_queue[0].drain && packet_results.size() != 0) nxt_valid = 1'b0;
        else if (!steady && $urandom_range(0, 99) < 22) nxt_valid = 1'b0;
        else nxt_valid = 1'b1;
      end
      s_axis_tvalid <= nxt_valid;
      if (nxt_valid) begin
        s_axis_tdata    <= byte_queue[0].data;
        s_axis_tuser[0] <= byte_queue[0].aux;
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    bit steady;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(result_t'(m_axis_tdata[OutW-1:0]));
      steady = bytes_taken >= SteadyLo && bytes_taken < SteadyHi;
      if (hold_left != 0) begin
        hold_left--;
      end else if (!hold_done && bytes_taken >= HoldAt) begin
        // long back-pressure so the tracker stalls its input
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      m_axis_tready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 22);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned pkt_no;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    pkt_buf[0] = '0;
    pkt_buf[1] = '0;
    pkt_buf[2] = '0;
    pkt_idx  = IDX_BUTTONS;
    last_btn = '0;
    press    = 1'b0;
    pos_x    = PosXReset;
    pos_y    = PosYReset;

    // directed: unflagged bytes, sign extremes, clamps, button ordering
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, 8'h00);
    push_packet(8'h05, 8'h80, 8'h7F);    // x and y clamp to zero, two buttons down
    push_packet(8'h04, 8'h7F, 8'h80);    // y delta of -128 adds 128, button 0 up
    push_packet(8'h04, 8'h00, 8'h00);    // no movement, no button change
    push_byte(1'b1, 8'hFB);
    push_byte(1'b0, 8'hA5);              // ignored byte inside a packet
    push_byte(1'b1, 8'h01);
    push_byte(1'b1, 8'hFF);
    push_packet(8'h00, 8'h00, 8'h01, 1'b1);
    push_packet(8'hFF, 8'h80, 8'h80);
    push_packet(8'h02, 8'h00, 8'h00);

    pkt_no = 0;
    while (flagged_count < FlaggedTarget) begin
      if ($urandom_range(0, 99) < 12) push_byte(1'b0, 8'($urandom_range(0, 255)));
      b0 = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15) begin
        b1 = 8'h00;
        b2 = 8'h00;
      end else begin
        b1 = 8'($urandom_range(0, 255));
        b2 = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 8) begin
        push_byte(1'b1, b0, pkt_no == 200 || pkt_no == 520);
        push_byte(1'b0, 8'($urandom_range(0, 255)));
        push_byte(1'b1, b1);
        push_byte(1'b1, b2);
      end else begin
        push_packet(b0, b1, b2, pkt_no == 200 || pkt_no == 520);
      end
      pkt_no++;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (byte_queue.size() != 0 || packet_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && packet_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> ps2_mouse_packet_tracker.f
hw/rtl/ps2mpt_pkg.sv
hw/rtl/ps2_mouse_packet_tracker.sv
bench/tb.sv
